FILE: design/bitmap_sort_engine_top_defines.svh
// assertion macros used by the bitmap sort engine back end
`ifndef BITMAP_SORT_ENGINE_TOP_DEFINES_SVH
`define BITMAP_SORT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bse_pkg.sv
// shared constants for the bitmap sort engine
package bse_pkg;

	localparam int VALUE_W    = 20;
	localparam int LIMIT_W    = 21;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam int FIFO_DEPTH = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'h100000;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FETCH  = 1'b1;

	localparam logic [APB_ADDR_W-1:0] ADDR_VALUE_LIMIT = 2'd0;

endpackage

FILE: design/bse_if.sv
// item and result channel interfaces of the bitmap sort engine
interface bse_item_if;
	import bse_pkg::*;

	logic               valid;
	logic               ready;
	logic               cmd;
	logic [VALUE_W-1:0] value;

	modport source(output valid, output cmd, output value, input ready);
	modport sink(input valid, input cmd, input value, output ready);
endinterface

interface bse_result_if;
	import bse_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] sorted_value;
	logic               found;

	modport source(output valid, output sorted_value, output found, input ready);
	modport sink(input valid, input sorted_value, input found, output ready);
endinterface

FILE: design/bse_apb_regs.sv
// apb configuration register of the bitmap sort engine
module bse_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bse_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bse_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bse_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [bse_pkg::LIMIT_W-1:0]     value_limit
);
	import bse_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;

	assign pready      = 1'b1;
	assign wr_en       = psel && penable && pwrite && pready && (paddr == ADDR_VALUE_LIMIT);
	assign value_limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_VALUE_LIMIT) begin
			prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_q};
		end
	end
endmodule

FILE: design/bse_front.sv
// front end: takes items, checks the limit and splits values into word and bit index
module bse_front #(
	parameter int VALUE_BITS = 20,
	parameter int WORD_BITS  = 64,
	parameter int ENTRY_W    = 22
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bse_item_if.sink                     item,
	input  logic [bse_pkg::LIMIT_W-1:0]  value_limit,
	input  logic                         clear_busy,
	output logic                         push_valid,
	output logic [ENTRY_W-1:0]           push_data,
	input  logic                         push_ready
);
	import bse_pkg::*;

	localparam int WORD_COUNT = ((1 << VALUE_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int WI_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BI_W       = $clog2(WORD_BITS);
	localparam int S_SHIFT    = VALUE_BITS + BI_W;
	localparam int M_W        = VALUE_BITS + 1;
	localparam int P_W        = 2 * VALUE_BITS + 2;
	localparam int QW_W       = VALUE_BITS + BI_W + 1;
	localparam int LW         = VALUE_BITS + LIMIT_W;
	localparam int XW         = VALUE_BITS + VALUE_W;
	localparam logic [M_W-1:0]  RECIP   = M_W'((longint'(1) << S_SHIFT) / WORD_BITS);
	localparam logic [BI_W:0]   WB_WIDE = (BI_W+1)'(WORD_BITS);

	logic                  advance;
	logic                  accept;
	logic [XW-1:0]         value_ext;
	logic [VALUE_BITS-1:0] value_in;

	logic                  v_s1, v_s2, v_s3;
	logic                  cmd_s1, cmd_s2, cmd_s3;
	logic                  ok_s1, ok_s2, ok_s3;
	logic [VALUE_BITS-1:0] val_s1, val_s2, val_s3;
	logic [P_W-1:0]        prod_s2;
	logic [WI_W-1:0]       q0_s3;
	logic [VALUE_BITS-1:0] qw_s3;

	logic [VALUE_BITS:0]   diff;
	logic [BI_W:0]         rem;
	logic [WI_W-1:0]       wi;
	logic [BI_W-1:0]       bi;

	assign value_ext  = {{VALUE_BITS{1'b0}}, item.value};
	assign value_in   = value_ext[VALUE_BITS-1:0];
	assign advance    = !v_s3 || push_ready;
	assign item.ready = advance && !clear_busy;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1  <= item.cmd;
			ok_s1   <= (LW'(value_in) < LW'(value_limit));
			val_s1  <= value_in;
			cmd_s2  <= cmd_s1;
			ok_s2   <= ok_s1;
			val_s2  <= val_s1;
			prod_s2 <= P_W'(val_s1) * P_W'(RECIP);
			cmd_s3  <= cmd_s2;
			ok_s3   <= ok_s2;
			val_s3  <= val_s2;
			q0_s3   <= prod_s2[S_SHIFT +: WI_W];
			qw_s3   <= VALUE_BITS'(QW_W'(prod_s2[S_SHIFT +: WI_W]) * QW_W'(WORD_BITS));
		end
	end

	// reciprocal quotient is short by at most one
	always_comb begin
		diff = {1'b0, val_s3} - {1'b0, qw_s3};
		rem  = diff[BI_W:0];
		if (rem >= WB_WIDE) begin
			wi = WI_W'(q0_s3 + 1'b1);
			bi = BI_W'(rem - WB_WIDE);
		end else begin
			wi = q0_s3;
			bi = rem[BI_W-1:0];
		end
	end

	assign push_valid = v_s3;
	assign push_data  = {cmd_s3, ok_s3, wi, bi};
endmodule

FILE: design/bse_fifo.sv
// small queue between front and back end
module bse_fifo #(
	parameter int DATA_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  logic [DATA_W-1:0] push_data,
	output logic              push_ready,
	input  logic              pop,
	output logic              q_valid,
	output logic [DATA_W-1:0] q_data
);
	import bse_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [DATA_W-1:0] store_q [FIFO_DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [AW:0]       count_q;
	logic              push;
	logic              pull;

	assign push_ready = (count_q != (AW+1)'(FIFO_DEPTH));
	assign q_valid    = (count_q != '0);
	assign q_data     = store_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pull       = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= AW'(wr_ptr_q + 1'b1);
			end
			if (pull) begin
				rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pull) begin
				count_q <= (AW+1)'(count_q + 1'b1);
			end else if (pull && !push) begin
				count_q <= (AW+1)'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

FILE: design/bse_back.sv
// back end: bitmap store, clearing pass after reset, insert read-modify-write and fetch scan
`include "bitmap_sort_engine_top_defines.svh"

module bse_back #(
	parameter int VALUE_BITS = 20,
	parameter int WORD_BITS  = 64,
	parameter int ENTRY_W    = 22
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               q_pop,
	output logic               clear_busy,
	bse_result_if.source       result
);
	import bse_pkg::*;

	localparam int WORD_COUNT = ((1 << VALUE_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int WI_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BI_W       = $clog2(WORD_BITS);
	localparam int FV_W       = VALUE_BITS + BI_W + 1;
	localparam int XW         = VALUE_BITS + VALUE_W;
	localparam logic [WI_W-1:0]      LAST_WI  = WI_W'(WORD_COUNT - 1);
	localparam logic [BI_W-1:0]      LAST_BIT = BI_W'(((1 << VALUE_BITS) - 1) % WORD_BITS);
	localparam logic [BI_W-1:0]      WB_LAST  = BI_W'(WORD_BITS - 1);
	localparam logic [WORD_BITS-1:0] ONES     = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_WR,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WI_W-1:0]      raddr, waddr;
	logic [WORD_BITS-1:0] wdata;
	logic                 wen;

	logic                 q_cmd, q_ok;
	logic [WI_W-1:0]      q_wi;
	logic [BI_W-1:0]      q_bi;

	logic [WI_W-1:0]      clr_idx_q;
	logic [WI_W-1:0]      ins_wi_q;
	logic [BI_W-1:0]      ins_bi_q;
	logic [WI_W-1:0]      scan_wi_q;
	logic                 first_q;
	logic [WI_W-1:0]      ptr_wi_q;
	logic [BI_W-1:0]      ptr_bi_q;
	logic [WORD_BITS-1:0] iso_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic                 out_found_q;

	logic                  slot_free;
	logic [WORD_BITS-1:0]  w_scan, w_iso;
	logic                  w_hit;
	logic [BI_W-1:0]       b_idx;
	logic [FV_W-1:0]       fv_full;
	logic [XW-1:0]         found_ext;

	assign {q_cmd, q_ok, q_wi, q_bi} = q_data;
	assign slot_free  = !out_valid_q || result.ready;
	assign clear_busy = (state_q == ST_CLEAR);

	assign w_scan = rdata_q & (first_q ? (ONES << ptr_bi_q) : ONES);
	assign w_hit  = |w_scan;
	assign w_iso  = w_scan & (~w_scan + WORD_BITS'(1));

	always_comb begin
		b_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso_q[i]) begin
				b_idx = b_idx | BI_W'(i);
			end
		end
	end

	assign fv_full   = FV_W'(scan_wi_q) * FV_W'(WORD_BITS) + FV_W'(b_idx);
	assign found_ext = {{VALUE_W{1'b0}}, fv_full[VALUE_BITS-1:0]};

	always_comb begin
		raddr = scan_wi_q;
		waddr = scan_wi_q;
		wdata = word_q;
		wen   = 1'b0;
		q_pop = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wen   = 1'b1;
				waddr = clr_idx_q;
				wdata = '0;
			end
			ST_IDLE: begin
				q_pop = q_valid && ((q_cmd == CMD_INSERT) || slot_free);
				raddr = (q_cmd == CMD_INSERT) ? q_wi : ptr_wi_q;
			end
			ST_INS_WR: begin
				wen   = 1'b1;
				waddr = ins_wi_q;
				wdata = rdata_q | (WORD_BITS'(1) << ins_bi_q);
			end
			ST_SCAN: begin
				raddr = WI_W'(scan_wi_q + 1'b1);
			end
			ST_EMIT: begin
				wen = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			ins_wi_q    <= '0;
			ins_bi_q    <= '0;
			scan_wi_q   <= '0;
			first_q     <= 1'b0;
			ptr_wi_q    <= '0;
			ptr_bi_q    <= '0;
			iso_q       <= '0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_found_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= WI_W'(clr_idx_q + 1'b1);
					if (clr_idx_q == LAST_WI) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						if (q_cmd == CMD_INSERT) begin
							if (q_ok) begin
								ins_wi_q <= q_wi;
								ins_bi_q <= q_bi;
								state_q  <= ST_INS_WR;
							end
						end else begin
							scan_wi_q <= ptr_wi_q;
							first_q   <= 1'b1;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_INS_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (w_hit) begin
						iso_q   <= w_iso;
						word_q  <= rdata_q & ~w_iso;
						state_q <= ST_EMIT;
					end else if (scan_wi_q == LAST_WI) begin
						ptr_wi_q    <= '0;
						ptr_bi_q    <= '0;
						out_valid_q <= 1'b1;
						out_value_q <= '0;
						out_found_q <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						scan_wi_q <= WI_W'(scan_wi_q + 1'b1);
						first_q   <= 1'b0;
					end
				end
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					out_value_q <= found_ext[VALUE_W-1:0];
					out_found_q <= 1'b1;
					if ((scan_wi_q == LAST_WI) && (b_idx == LAST_BIT)) begin
						ptr_wi_q <= '0;
						ptr_bi_q <= '0;
					end else if (b_idx == WB_LAST) begin
						ptr_wi_q <= WI_W'(scan_wi_q + 1'b1);
						ptr_bi_q <= '0;
					end else begin
						ptr_wi_q <= scan_wi_q;
						ptr_bi_q <= BI_W'(b_idx + 1'b1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.sorted_value = out_value_q;
	assign result.found        = out_found_q;

	`BSE_ASSERT_NOW(a_emit_slot_free, state_q == ST_EMIT, !out_valid_q, "result slot busy at emit")
	`BSE_ASSERT_NOW(a_emit_onehot, state_q == ST_EMIT, $onehot(iso_q), "emit bit not one-hot")
	`BSE_ASSERT_NEXT(a_clear_once, state_q != ST_CLEAR, state_q != ST_CLEAR, "clear pass re-entered")
	`BSE_ASSERT_NEXT(a_scan_step, (state_q == ST_SCAN) && !w_hit && (scan_wi_q != LAST_WI), (state_q == ST_SCAN) && (scan_wi_q == $past(scan_wi_q) + 1'b1), "scan skipped a word")
	`BSE_ASSERT_NOW(a_exhaust_zero, out_valid_q && !out_found_q, out_value_q == '0, "exhausted result not zero")
endmodule

FILE: design/bitmap_sort_engine_top.sv
// bitmap sort engine top level
// Inserts set one bit per value in a bitmap of 2^VALUE_BITS bits held as WORD_BITS-bit
// words in a single-port-write memory; fetches return the set values in ascending order,
// clearing each as it goes, and answer found = 0 (scan restarted) when none remain from
// the scan pointer to the top. After reset a clearing pass writes all 2^VALUE_BITS /
// WORD_BITS words (16384 at the defaults), and no item is taken until it ends; the
// value_limit register can be written meanwhile. Items go through a three-stage front
// end that checks the limit and splits the value into word and bit index, then a
// four-entry queue. The back end reads, then writes, the word of an insert, and drops
// a value at or above the limit. A fetch reads one word per cycle from the scan pointer
// upward until it finds a set bit, then writes the word back with that bit cleared; an
// exhausted fetch scans to the top. The memory port and this scan set the rate; results
// sit in an output register, and a fetch waits in the queue until that register is free.
module bitmap_sort_engine_top #(
	parameter int VALUE_BITS = 20,
	parameter int WORD_BITS  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bse_item_if.sink                        item,
	bse_result_if.source                    result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bse_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bse_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bse_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import bse_pkg::*;

	localparam int WORD_COUNT = ((1 << VALUE_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int WI_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BI_W       = $clog2(WORD_BITS);
	localparam int ENTRY_W    = 2 + WI_W + BI_W;

	logic [LIMIT_W-1:0] value_limit;
	logic               clear_busy;
	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               q_valid;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_data;

	bse_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.value_limit (value_limit)
	);

	bse_front #(
		.VALUE_BITS (VALUE_BITS),
		.WORD_BITS  (WORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.value_limit (value_limit),
		.clear_busy  (clear_busy),
		.push_valid  (push_valid),
		.push_data   (push_data),
		.push_ready  (push_ready)
	);

	bse_fifo #(
		.DATA_W (ENTRY_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (q_pop),
		.q_valid    (q_valid),
		.q_data     (q_data)
	);

	bse_back #(
		.VALUE_BITS (VALUE_BITS),
		.WORD_BITS  (WORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.result     (result)
	);
endmodule
